FILE: rtl/cst_pkg.sv
package cst_pkg;

  localparam int CntW = 16;

  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_WAIT   = 2'd1;
  localparam logic [1:0] CMD_SIGNAL = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_BADID  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [CntW-1:0] CNT_MIN = 16'h8000;
  localparam logic [CntW-1:0] CNT_MAX = 16'h7FFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } ctl_state_t;

endpackage

FILE: rtl/cst_ram.sv
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/counting_semaphore_table_core.sv
// Counting semaphore table with a FIFO of waiting process ids per semaphore.
//
// Input channel: drive in_command, in_sem_id, in_init_value and in_proc_id
// with start high; the item is taken at a rising edge where busy is low.
// Commands: init allocates the lowest free semaphore and loads its count,
// wait decrements the count and queues the caller when it goes negative,
// signal increments the count and pops the oldest waiter to wake.
//
// Result channel: exactly one result per item, shown for one cycle with
// out_valid high in the result state, which follows the execute state.
// The receiver cannot stall; it must take the result in that cycle.
//
// Steps: the entry (count, queue length, queue head) is read from the state
// memory as the item is taken; the execute state updates it, writes it back
// and pushes to or reads from the waiter memory. busy is high only there, so
// the next item is read in the result cycle, after the write back has landed.
//
// Reset (synchronous, rst_n low) clears all allocation marks and the valid
// bit of every state entry, so all counts and queue lengths read as zero.
// The waiter memory is not cleared; no clearing pass is needed.
module counting_semaphore_table_core #(
  parameter int NUM_SEMS    = 32,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_sem_id,
  input  logic signed [15:0] in_init_value,
  input  logic [7:0]  in_proc_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [4:0]  out_alloc_id,
  output logic        out_must_block,
  output logic        out_wake_valid,
  output logic [7:0]  out_wake_proc
);

  localparam int SW   = $clog2(NUM_SEMS);
  localparam int LW   = $clog2(QUEUE_DEPTH + 1);
  localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = cst_pkg::CntW;
  localparam int EW   = CW + LW + HW;
  localparam int WDEP = NUM_SEMS * QUEUE_DEPTH;
  localparam int AW   = $clog2(WDEP);

  cst_pkg::ctl_state_t state_r, state_nxt;

  logic accept;

  // captured item
  logic [1:0]    cmd_r;
  logic [7:0]    pid_r;
  logic [CW-1:0] ival_r;
  logic          bad_r;
  logic          found_r;
  logic          hit_r;
  logic [SW-1:0] tgt_r;

  logic [NUM_SEMS-1:0] alloc_r;
  logic [NUM_SEMS-1:0] stv_r;

  logic [SW-1:0] free_idx;
  logic          free_ok;
  logic [SW-1:0] tgt_nxt;
  logic          bad_nxt;

  // state memory
  logic          swe;
  logic [EW-1:0] swdata;
  logic [EW-1:0] srdata;

  // waiter memory
  logic          wwe;
  logic          wre;
  logic [AW-1:0] waddr;
  logic [7:0]    wrdata;

  logic [CW-1:0] cur_cnt;
  logic [LW-1:0] cur_len;
  logic [HW-1:0] cur_head;
  logic [CW-1:0] new_cnt;
  logic [LW-1:0] new_len;
  logic [HW-1:0] new_head;
  logic [LW:0]   tail_sum;
  logic [LW:0]   head_inc;
  logic [HW-1:0] tail_idx;
  logic [HW-1:0] head_nxt_idx;
  logic [AW-1:0] qbase;

  logic [1:0] status_r, status_nxt;
  logic [4:0] aid_r, aid_nxt;
  logic       block_r, block_nxt;
  logic       wake_r, wake_nxt;
  logic       set_alloc;
  logic [7:0] tgt_ext;

  assign accept = start && !busy;

  // lowest free semaphore
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_idx = SW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  assign bad_nxt = (7'(in_sem_id) >= 7'(NUM_SEMS));
  assign tgt_nxt = (in_command == cst_pkg::CMD_INIT) ? free_idx : in_sem_id[SW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      pid_r   <= in_proc_id;
      ival_r  <= in_init_value;
      bad_r   <= bad_nxt;
      found_r <= free_ok;
      tgt_r   <= tgt_nxt;
      hit_r   <= stv_r[tgt_nxt];
    end
  end

  cst_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_SEMS)
  ) u_state_ram (
    .clk  (clk),
    .we   (swe),
    .waddr(tgt_r),
    .wdata(swdata),
    .re   (accept),
    .raddr(tgt_nxt),
    .rdata(srdata)
  );

  cst_ram #(
    .WIDTH(8),
    .DEPTH(WDEP)
  ) u_waiter_ram (
    .clk  (clk),
    .we   (wwe),
    .waddr(waddr),
    .wdata(pid_r),
    .re   (wre),
    .raddr(waddr),
    .rdata(wrdata)
  );

  // an entry never written since reset reads as zero
  assign cur_cnt  = hit_r ? srdata[EW-1 -: CW] : '0;
  assign cur_len  = hit_r ? srdata[HW +: LW] : '0;
  assign cur_head = hit_r ? srdata[HW-1:0] : '0;

  assign tail_sum     = (LW+1)'(cur_head) + (LW+1)'(cur_len);
  assign tail_idx     = (tail_sum >= (LW+1)'(QUEUE_DEPTH))
                        ? HW'(tail_sum - (LW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign head_inc     = (LW+1)'(cur_head) + (LW+1)'(1);
  assign head_nxt_idx = (head_inc == (LW+1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
  assign qbase        = AW'(tgt_r) * AW'(QUEUE_DEPTH);
  assign tgt_ext      = 8'(tgt_r);

  // update of one semaphore entry
  always_comb begin
    new_cnt    = cur_cnt;
    new_len    = cur_len;
    new_head   = cur_head;
    swe        = 1'b0;
    wwe        = 1'b0;
    wre        = 1'b0;
    waddr      = qbase + AW'(cur_head);
    set_alloc  = 1'b0;
    status_nxt = cst_pkg::ST_OK;
    aid_nxt    = '0;
    block_nxt  = 1'b0;
    wake_nxt   = 1'b0;
    if (state_r == cst_pkg::S_EXEC) begin
      unique case (cmd_r)
        cst_pkg::CMD_INIT: begin
          if (found_r) begin
            new_cnt   = ival_r;
            swe       = 1'b1;
            set_alloc = 1'b1;
            aid_nxt   = tgt_ext[4:0];
          end else begin
            status_nxt = cst_pkg::ST_NOFREE;
          end
        end
        cst_pkg::CMD_WAIT: begin
          if (bad_r) begin
            status_nxt = cst_pkg::ST_BADID;
          end else begin
            swe = 1'b1;
            if (cur_cnt != cst_pkg::CNT_MIN) begin
              new_cnt = cur_cnt - CW'(1);
            end
            if (new_cnt[CW-1]) begin
              if (cur_len >= LW'(QUEUE_DEPTH)) begin
                // count stays decremented
                status_nxt = cst_pkg::ST_FULL;
              end else begin
                wwe       = 1'b1;
                waddr     = qbase + AW'(tail_idx);
                new_len   = cur_len + LW'(1);
                block_nxt = 1'b1;
              end
            end
          end
        end
        cst_pkg::CMD_SIGNAL: begin
          if (bad_r) begin
            status_nxt = cst_pkg::ST_BADID;
          end else begin
            swe = 1'b1;
            if (cur_cnt != cst_pkg::CNT_MAX) begin
              new_cnt = cur_cnt + CW'(1);
            end
            if (cur_len != '0) begin
              wre      = 1'b1;
              new_len  = cur_len - LW'(1);
              new_head = head_nxt_idx;
              wake_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign swdata = {new_cnt, new_len, new_head};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      stv_r   <= '0;
    end else begin
      if (set_alloc) begin
        alloc_r[tgt_r] <= 1'b1;
      end
      if (swe) begin
        stv_r[tgt_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cst_pkg::S_EXEC) begin
      status_r <= status_nxt;
      aid_r    <= aid_nxt;
      block_r  <= block_nxt;
      wake_r   <= wake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cst_pkg::S_IDLE: if (accept) state_nxt = cst_pkg::S_EXEC;
      cst_pkg::S_EXEC: state_nxt = cst_pkg::S_RESP;
      cst_pkg::S_RESP: state_nxt = accept ? cst_pkg::S_EXEC : cst_pkg::S_IDLE;
      default:         state_nxt = cst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r == cst_pkg::S_EXEC);
    out_valid = (state_r == cst_pkg::S_RESP);
  end

  assign out_status     = status_r;
  assign out_alloc_id   = aid_r;
  assign out_must_block = block_r;
  assign out_wake_valid = wake_r;
  assign out_wake_proc  = wake_r ? wrdata : 8'd0;

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cst_pkg::S_EXEC) |-> $past(accept))
    else $error("execute cycle without an accepted item");

  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == cst_pkg::S_EXEC))
    else $error("result without an execute cycle");

  a_block_wake_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_must_block && out_wake_valid))
    else $error("result both blocks and wakes");

  a_no_write_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
    (swe && (cmd_r != cst_pkg::CMD_INIT)) |-> !bad_r)
    else $error("state write for a bad id");

  a_waiter_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wwe && wre))
    else $error("waiter memory pushed and popped at once");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int NUM_SEMS    = 32;
  localparam int QUEUE_DEPTH = 16;
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  sem;
    logic [15:0] value;
    logic [7:0]  pid;
  } sem_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] alloc_id;
    logic       must_block;
    logic       wake_valid;
    logic [7:0] wake_proc;
  } sem_reply_t;

  class sem_table_sb;
    logic                     allocated [NUM_SEMS];
    logic [cst_pkg::CntW-1:0] count [NUM_SEMS];
    logic [7:0]               waiters [NUM_SEMS][$];
    sem_reply_t               pending_replies [$];
    int                       errors;

    function new();
      for (int s = 0; s < NUM_SEMS; s++) begin
        allocated[s] = 1'b0;
        count[s] = '0;
      end
      errors = 0;
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction

    // Update the table copy for one accepted item and queue its reply.
    function void take_command(sem_cmd_t c);
      sem_reply_t r;
      int s;
      bit found;
      r = '0;
      found = 1'b0;
      case (c.cmd)
        cst_pkg::CMD_INIT: begin
          r.status = cst_pkg::ST_NOFREE;
          for (s = 0; s < NUM_SEMS; s++) begin
            if (!found && !allocated[s]) begin
              found = 1'b1;
              allocated[s] = 1'b1;
              count[s] = c.value;
              r.status = cst_pkg::ST_OK;
              r.alloc_id = 5'(s);
            end
          end
        end
        cst_pkg::CMD_WAIT, cst_pkg::CMD_SIGNAL: begin
          if (c.sem >= NUM_SEMS) begin
            r.status = cst_pkg::ST_BADID;
          end else if (c.cmd == cst_pkg::CMD_WAIT) begin
            s = c.sem;
            if (count[s] != cst_pkg::CNT_MIN) count[s] = count[s] - 1'b1;
            if (count[s][cst_pkg::CntW-1]) begin
              if (waiters[s].size() >= QUEUE_DEPTH) begin
                r.status = cst_pkg::ST_FULL;
              end else begin
                waiters[s].push_back(c.pid);
                r.must_block = 1'b1;
              end
            end
          end else begin
            s = c.sem;
            if (count[s] != cst_pkg::CNT_MAX) count[s] = count[s] + 1'b1;
            if (waiters[s].size() > 0) begin
              r.wake_valid = 1'b1;
              r.wake_proc = waiters[s].pop_front();
            end
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(sem_reply_t got);
      sem_reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: reply with nothing outstanding, expected none got %0h", $time, got);
        return;
      end
      want = pending_replies.pop_front();
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("alloc_id", 8'(want.alloc_id), 8'(got.alloc_id));
      check_field("must_block", 8'(want.must_block), 8'(got.must_block));
      check_field("wake_valid", 8'(want.wake_valid), 8'(got.wake_valid));
      check_field("wake_proc", want.wake_proc, got.wake_proc);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_command = cst_pkg::CMD_INIT;
  logic [5:0]         in_sem_id = '0;
  logic signed [15:0] in_init_value = '0;
  logic [7:0]         in_proc_id = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [4:0]         out_alloc_id;
  logic               out_must_block;
  logic               out_wake_valid;
  logic [7:0]         out_wake_proc;

  sem_table_sb sb = new();

  counting_semaphore_table_core #(
    .NUM_SEMS(NUM_SEMS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_sem_id(in_sem_id),
    .in_init_value(in_init_value),
    .in_proc_id(in_proc_id),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_alloc_id(out_alloc_id),
    .out_must_block(out_must_block),
    .out_wake_valid(out_wake_valid),
    .out_wake_proc(out_wake_proc)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_reply({out_status, out_alloc_id, out_must_block, out_wake_valid,
                      out_wake_proc});
  end

  // Leave start high on return so back-to-back items need no extra edge.
  task automatic issue(input logic [1:0] cmd, input logic [5:0] sem,
                       input logic [15:0] value, input logic [7:0] pid);
    sem_cmd_t c;
    c = '{cmd: cmd, sem: sem, value: value, pid: pid};
    start <= 1'b1;
    in_command <= cmd;
    in_sem_id <= sem;
    in_init_value <= value;
    in_proc_id <= pid;
    do @(posedge clk); while (busy);
    sb.take_command(c);
  endtask

  task automatic hold_off(input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic sem_cmd_t rand_cmd(int wait_pct);
    sem_cmd_t c;
    int r;
    r = $urandom_range(99);
    if (r < 5) c.cmd = cst_pkg::CMD_INIT;
    else if (r < 9) c.cmd = CMD_NONE;
    else if (r < 9 + wait_pct) c.cmd = cst_pkg::CMD_WAIT;
    else c.cmd = cst_pkg::CMD_SIGNAL;
    // Concentrate on a few semaphores so queues fill and drain.
    r = $urandom_range(99);
    if (r < 70) c.sem = 6'($urandom_range(5));
    else if (r < 95) c.sem = 6'($urandom_range(NUM_SEMS - 1));
    else c.sem = 6'($urandom_range(63, NUM_SEMS));
    case ($urandom_range(7))
      0: c.value = cst_pkg::CNT_MIN;
      1: c.value = cst_pkg::CNT_MAX;
      2: c.value = '1;
      3: c.value = '0;
      default: c.value = 16'($urandom);
    endcase
    c.pid = 8'($urandom);
    return c;
  endfunction

  initial begin
    int idle_pct [4];
    int wait_pct [4];
    int guard;
    sem_cmd_t c;
    idle_pct = '{0, 86, 22, 0};
    wait_pct = '{60, 55, 35, 55};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturation at both ends.
    issue(cst_pkg::CMD_INIT, 6'd0, cst_pkg::CNT_MAX, 8'h00);
    issue(cst_pkg::CMD_INIT, 6'd0, cst_pkg::CNT_MIN, 8'h00);
    issue(cst_pkg::CMD_INIT, 6'd0, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_SIGNAL, 6'd0, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_WAIT, 6'd0, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_WAIT, 6'd1, 16'hFFFF, 8'hFF);
    issue(cst_pkg::CMD_WAIT, 6'd1, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_SIGNAL, 6'd1, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_SIGNAL, 6'd1, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_WAIT, 6'd2, 16'h0000, 8'h5A);
    // Queue on an unallocated entry survives a later init of it.
    issue(cst_pkg::CMD_WAIT, 6'd5, 16'h0000, 8'h33);
    issue(cst_pkg::CMD_INIT, 6'd0, 16'h0001, 8'h00);
    issue(cst_pkg::CMD_INIT, 6'd0, 16'hFFFF, 8'h00);
    issue(cst_pkg::CMD_INIT, 6'd0, 16'h0007, 8'h00);
    issue(cst_pkg::CMD_SIGNAL, 6'd5, 16'h0000, 8'h00);
    // Bad ids, the unused command and the highest valid id.
    issue(cst_pkg::CMD_WAIT, 6'd32, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_SIGNAL, 6'd63, 16'h0000, 8'h00);
    issue(CMD_NONE, 6'd0, 16'hFFFF, 8'hFF);
    issue(cst_pkg::CMD_SIGNAL, 6'd31, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_WAIT, 6'd31, 16'h0000, 8'hAA);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 275; n++) begin
        hold_off(idle_pct[ph]);
        c = rand_cmd(wait_pct[ph]);
        issue(c.cmd, c.sem, c.value, c.pid);
      end
      drain();
    end

    start <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t: %0d replies never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[counting_semaphore_table_core] OK");
    end else begin
      $display("[counting_semaphore_table_core] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[counting_semaphore_table_core] ERROR");
    $finish;
  end

endmodule
